// ===== rtl/smi_pkg.sv =====
package smi_pkg;

    localparam int ELEM_W        = 32;
    localparam int STORE_DEPTH   = 16;
    localparam int ADDR_W        = 4;
    localparam int POS_W         = 4;
    localparam int DIM_W         = 3;
    localparam int IDX_W         = 2;
    localparam int TERMS         = 24;
    localparam int TERM_W        = 5;
    localparam int CNT_W         = 5;
    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_RESET     = 4;

    typedef struct packed {
        logic              par;
        logic [3:0][1:0]   idx;
    } t_perm;

    typedef t_perm [TERMS-1:0] t_perm_tab;

    typedef struct packed {
        logic start;
        logic div;
    } t_mac_cmd;

    // term t of the leibniz sum; the first k! terms only permute the first k places
    function automatic t_perm_tab build_perm();
        t_perm_tab  tab;
        logic [1:0] p [4];
        logic [1:0] tmp;
        logic       par;
        int         d [4];
        for (int t = 0; t < TERMS; t++) begin
            for (int j = 0; j < 4; j++) begin
                p[j] = 2'(j);
            end
            par  = 1'b0;
            d[0] = 0;
            d[1] = t % 2;
            d[2] = (t / 2) % 3;
            d[3] = t / 6;
            for (int j = 1; j < 4; j++) begin
                if (d[j] != 0) begin
                    tmp         = p[j];
                    p[j]        = p[j - d[j]];
                    p[j - d[j]] = tmp;
                    par         = ~par;
                end
            end
            tab[t].par = par;
            for (int j = 0; j < 4; j++) begin
                tab[t].idx[j] = p[j];
            end
        end
        return tab;
    endfunction

    localparam t_perm_tab PERM_TAB = build_perm();

    function automatic logic [TERM_W-1:0] fact(input logic [DIM_W-1:0] k);
        logic [TERM_W-1:0] f;
        unique case (k)
            3'd2:    f = 5'd2;
            3'd3:    f = 5'd6;
            3'd4:    f = 5'd24;
            default: f = 5'd1;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/smi_mac.sv =====
module smi_mac #(
    parameter int AW        = 134,
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  smi_pkg::t_mac_cmd         i_cmd,
    input  logic [AW-1:0]             i_a,
    input  logic [smi_pkg::ELEM_W-1:0] i_e,
    input  logic [AW-1:0]             i_num,
    input  logic [AW-1:0]             i_den,
    output logic                      o_done,
    output logic [AW-1:0]             o_prod,
    output logic [smi_pkg::ELEM_W-1:0] o_quot,
    output logic                      o_big
);
    import smi_pkg::*;

    localparam int NW = AW + 2 * FRAC_BITS;
    localparam int W  = AW + 2;
    localparam int CW = $clog2(NW);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MUL  = 5'b00010,
        M_NEG  = 5'b00100,
        M_DIV  = 5'b01000,
        M_DONE = 5'b10000
    } t_mstate;

    t_mstate            r_state, n_state;
    logic [AW-1:0]      r_acc;
    logic [AW-1:0]      r_m;
    logic [ELEM_W-1:0]  r_e;
    logic               r_eneg;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_rem;
    logic [NW-1:0]      r_num;
    logic [AW-1:0]      r_den;
    logic [ELEM_W-1:0]  r_q;
    logic               r_big;

    logic [W-1:0]       add_a, add_b, sum;
    logic               add_sub;
    logic [AW:0]        shifted;
    logic               ge;

    assign shifted = {r_rem, r_num[NW-1]};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            M_MUL: begin
                add_a = {2'b00, r_acc};
                add_b = {2'b00, r_m};
            end
            M_NEG: begin
                add_b   = {2'b00, r_acc};
                add_sub = 1'b1;
            end
            M_DIV: begin
                add_a   = {1'b0, shifted};
                add_b   = {2'b00, r_den};
                add_sub = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
        sum = add_a + (add_b ^ {W{add_sub}}) + W'(add_sub);
    end

    assign ge = ~sum[W-1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.div ? M_DIV : M_MUL;
                end
            end
            M_MUL: begin
                if (r_cnt == CW'(ELEM_W - 1)) begin
                    n_state = r_eneg ? M_NEG : M_DONE;
                end
            end
            M_NEG:   n_state = M_DONE;
            M_DIV: begin
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = M_DONE;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                r_cnt <= '0;
                if (i_cmd.start) begin
                    r_acc  <= '0;
                    r_m    <= i_a;
                    r_e    <= i_e[ELEM_W-1] ? (ELEM_W'(0) - i_e) : i_e;
                    r_eneg <= i_e[ELEM_W-1];
                    r_rem  <= '0;
                    r_num  <= NW'(i_num) << (2 * FRAC_BITS);
                    r_den  <= i_den;
                    r_q    <= '0;
                    r_big  <= 1'b0;
                end
            end
            M_MUL: begin
                if (r_e[0]) begin
                    r_acc <= sum[AW-1:0];
                end
                r_m   <= r_m << 1;
                r_e   <= r_e >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            M_NEG: begin
                r_acc <= sum[AW-1:0];
            end
            M_DIV: begin
                r_rem <= ge ? sum[AW-1:0] : shifted[AW-1:0];
                r_num <= r_num << 1;
                r_big <= r_big | r_q[ELEM_W-1];
                r_q   <= {r_q[ELEM_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_done = (r_state == M_DONE);
    assign o_prod = r_acc;
    assign o_quot = r_q;
    assign o_big  = r_big;

endmodule

// ===== rtl/small_matrix_inverse.sv =====
// Inverts a square matrix of 1 to 4 rows (dimension register, 0 acts as 1, larger
// values as the maximum) by adjugate over determinant. Elements of signed Q16.16
// come in row-major, one per request; after the last one the block accepts nothing
// until every result has been taken. Results leave row-major with their position;
// a zero determinant gives a single result with the singular flag. Determinant and
// cofactors are exact Leibniz sums built by one shared shift-add unit, which also
// performs each division; an output stall holds the block. Writing the dimension
// restarts collection.
module small_matrix_inverse #(
    parameter int MAX_DIM   = smi_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [smi_pkg::DIM_W-1:0]  i_cfg_wr_data,   // dimension
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [31:0]                i_s_axis_tdata,  // element
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [39:0]                o_m_axis_tdata,  // value, position, zero fill
    output logic [1:0]                 o_m_axis_tuser,  // singular, saturated
    output logic                       o_m_axis_tlast
);
    import smi_pkg::*;

    localparam int AW = ELEM_W * MAX_DIM + 6;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_TERM  = 8'b0000_0010,
        S_ISSUE = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [DIM_W-1:0]     r_dim;
    logic [CNT_W-1:0]     r_cnt;
    logic [ELEM_W-1:0]    r_mem [STORE_DEPTH];
    logic [ELEM_W-1:0]    r_rd;
    logic                 r_det;
    logic [IDX_W-1:0]     r_r, r_c;
    logic [TERM_W-1:0]    r_t;
    logic [DIM_W-1:0]     r_i;
    logic [AW-1:0]        r_prod;
    logic [AW-1:0]        r_acc;
    logic [AW-1:0]        r_den;
    logic                 r_dneg;
    logic                 r_nneg;
    logic [ELEM_W-1:0]    r_val;
    logic [POS_W-1:0]     r_pos;
    logic                 r_sing, r_sat, r_last;

    logic [DIM_W-1:0]     dim_n;
    logic [DIM_W-1:0]     k;
    logic [CNT_W-1:0]     total;
    logic [DIM_W-1:0]     skip_r, skip_c;
    t_perm                perm;
    logic [IDX_W-1:0]     row_j, col_j;
    logic [DIM_W-1:0]     row, col;
    logic [ADDR_W-1:0]    addr;
    logic                 in_acc;
    logic                 last_elem;
    logic                 last_term;
    logic [AW-1:0]        acc_mag;
    logic                 qneg;
    t_mac_cmd             cmd;
    logic                 mac_done;
    logic [AW-1:0]        mac_prod;
    logic [ELEM_W-1:0]    mac_quot;
    logic                 mac_big;
    logic [ELEM_W-1:0]    val_n;
    logic                 sat_n;
    logic                 res_last;

    always_comb begin
        if (r_dim == '0) begin
            dim_n = DIM_W'(1);
        end else if (r_dim > DIM_W'(MAX_DIM)) begin
            dim_n = DIM_W'(MAX_DIM);
        end else begin
            dim_n = r_dim;
        end
    end

    assign k         = r_det ? dim_n : dim_n - 1'b1;
    assign total     = CNT_W'(dim_n) * CNT_W'(dim_n);
    assign skip_r    = r_det ? DIM_W'(4) : {1'b0, r_c};
    assign skip_c    = r_det ? DIM_W'(4) : {1'b0, r_r};
    assign perm      = PERM_TAB[r_t];
    assign row_j     = r_i[IDX_W-1:0];
    assign col_j     = perm.idx[row_j];
    assign row       = {1'b0, row_j} + DIM_W'({1'b0, row_j} >= skip_r);
    assign col       = {1'b0, col_j} + DIM_W'({1'b0, col_j} >= skip_c);
    assign addr      = ADDR_W'(row) * ADDR_W'(dim_n) + ADDR_W'(col);
    assign in_acc    = i_s_axis_tvalid && (r_state == S_LOAD);
    assign last_elem = (CNT_W'(r_cnt + 1'b1) >= total);
    assign last_term = (r_t == fact(k) - 1'b1);
    assign acc_mag   = r_acc[AW-1] ? (AW'(0) - r_acc) : r_acc;
    assign qneg      = r_nneg ^ r_dneg;
    assign res_last  = ({1'b0, r_r} == dim_n - 1'b1) && ({1'b0, r_c} == dim_n - 1'b1);

    assign cmd.start = (r_state == S_ISSUE) || (r_state == S_FIN && !r_det);
    assign cmd.div   = (r_state == S_FIN);

    always_comb begin
        sat_n = 1'b0;
        if (qneg) begin
            if (mac_big || mac_quot > 32'h8000_0000) begin
                val_n = 32'h8000_0000;
                sat_n = 1'b1;
            end else begin
                val_n = ELEM_W'(0) - mac_quot;
            end
        end else begin
            if (mac_big || mac_quot[ELEM_W-1]) begin
                val_n = 32'h7FFF_FFFF;
                sat_n = 1'b1;
            end else begin
                val_n = mac_quot;
            end
        end
    end

    smi_mac #(
        .AW        (AW),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_a     (r_prod),
        .i_e     (r_rd),
        .i_num   (acc_mag),
        .i_den   (r_den),
        .o_done  (mac_done),
        .o_prod  (mac_prod),
        .o_quot  (mac_quot),
        .o_big   (mac_big)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (in_acc && last_elem) n_state = S_TERM;
            S_TERM:  n_state = (r_i == k) ? S_ACC : S_ISSUE;
            S_ISSUE: n_state = S_MUL;
            S_MUL:   if (mac_done) n_state = S_TERM;
            S_ACC:   n_state = last_term ? S_FIN : S_TERM;
            S_FIN: begin
                if (r_det) begin
                    n_state = (r_acc == '0) ? S_OUT : S_TERM;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   if (mac_done) n_state = S_OUT;
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = r_last ? S_LOAD : S_TERM;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dim   <= DIM_W'(DIM_RESET);
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_dim <= i_cfg_wr_data;
                r_cnt <= '0;
            end else if (in_acc) begin
                r_cnt <= last_elem ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= i_s_axis_tdata;
        end
        if (r_state == S_TERM) begin
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                r_det  <= 1'b1;
                r_r    <= '0;
                r_c    <= '0;
                r_t    <= '0;
                r_i    <= '0;
                r_prod <= AW'(1);
                r_acc  <= '0;
            end
            S_MUL: begin
                if (mac_done) begin
                    r_prod <= mac_prod;
                    r_i    <= r_i + 1'b1;
                end
            end
            S_ACC: begin
                r_acc  <= perm.par ? r_acc - r_prod : r_acc + r_prod;
                r_prod <= AW'(1);
                r_i    <= '0;
                if (!last_term) begin
                    r_t <= r_t + 1'b1;
                end
            end
            S_FIN: begin
                r_t <= '0;
                if (r_det) begin
                    r_den  <= acc_mag;
                    r_dneg <= r_acc[AW-1];
                    r_det  <= 1'b0;
                    r_acc  <= '0;
                    r_val  <= '0;
                    r_pos  <= '0;
                    r_sing <= 1'b1;
                    r_sat  <= 1'b0;
                    r_last <= 1'b1;
                end else begin
                    r_nneg <= r_acc[AW-1] ^ r_r[0] ^ r_c[0];
                end
            end
            S_DIV: begin
                if (mac_done) begin
                    r_val  <= val_n;
                    r_sat  <= sat_n;
                    r_sing <= 1'b0;
                    r_pos  <= POS_W'(r_r) * POS_W'(dim_n) + POS_W'(r_c);
                    r_last <= res_last;
                end
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    r_acc  <= '0;
                    r_prod <= AW'(1);
                    r_i    <= '0;
                    r_t    <= '0;
                    if ({1'b0, r_c} == dim_n - 1'b1) begin
                        r_c <= '0;
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {4'b0000, r_pos, r_val};
    assign o_m_axis_tuser  = {r_sat, r_sing};
    assign o_m_axis_tlast  = r_last;

endmodule
